>>> rtl/flippable_stack_defines.svh
// Assertion macros shared by the flippable stack RTL.
`ifndef FLIPPABLE_STACK_DEFINES_SVH
`define FLIPPABLE_STACK_DEFINES_SVH

`ifndef ASSERT_OFF

// Condition holds on every clock edge outside reset.
`define FSTK_ASSERT(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define FSTK_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define FSTK_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define FSTK_ASSERT(lbl, clk, rst, expr, msg)
`define FSTK_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define FSTK_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

>>> rtl/fstk_pkg.sv
// Shared constants, codes and types of the flippable stack.
package fstk_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int FUNC_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 5;

   localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FLIP = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic capture;  // latch the accepted item
      logic exec;     // update pointers, write or read the store
      logic load;     // fill the result register
   } fstk_cmd_type;

endpackage

>>> rtl/fstk_if.sv
// Valid/ready channel interfaces for request and response items.
interface fstk_req_if;
   logic                               valid;
   logic                               ready;
   logic        [fstk_pkg::FUNC_W-1:0]  func;
   logic signed [fstk_pkg::VALUE_W-1:0] push_value;

   modport source (output valid, func, push_value, input ready);
   modport sink   (input valid, func, push_value, output ready);
endinterface

interface fstk_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [fstk_pkg::VALUE_W-1:0]  pop_value;
   logic        [fstk_pkg::STATUS_W-1:0] status;
   logic        [fstk_pkg::FILL_W-1:0]   fill_count;
   logic                                is_empty;

   modport source (output valid, pop_value, status, fill_count, is_empty, input ready);
   modport sink   (input valid, pop_value, status, fill_count, is_empty, output ready);
endinterface

>>> rtl/fstk_ram.sv
// Generic single write port, single read port RAM with registered read.
module fstk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/fstk_ctrl.sv
// Sequencing state machine of the flippable stack.
`include "flippable_stack_defines.svh"

module fstk_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output fstk_pkg::fstk_cmd_type cmd
);
   import fstk_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       can_load;

   // result register is free, or drains this cycle
   assign can_load = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (can_load) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `FSTK_ASSERT_NXT(a_accept_then_exec, clock, reset, req_valid && req_ready, cmd.exec,
                    "accepted item not executed next cycle")
   `FSTK_ASSERT_NXT(a_exec_then_load_state, clock, reset, cmd.exec, state_ff == ST_LOAD,
                    "exec not followed by load state")
   `FSTK_ASSERT_IMP(a_load_no_clobber, clock, reset, cmd.load, !rsp_valid_ff || rsp_ready,
                    "result register overwritten before taken")
   `FSTK_ASSERT_NXT(a_load_sets_valid, clock, reset, cmd.load, rsp_valid_ff,
                    "loaded result not presented")

endmodule

>>> rtl/fstk_dp.sv
// Datapath: pointers, count, direction, entry store and result register.
`include "flippable_stack_defines.svh"

module fstk_dp #(
   parameter int DEPTH      = fstk_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = fstk_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fstk_pkg::fstk_cmd_type              cmd,
   input  logic        [fstk_pkg::FUNC_W-1:0]   req_func,
   input  logic signed [fstk_pkg::VALUE_W-1:0]  req_push_value,
   output logic signed [fstk_pkg::VALUE_W-1:0]  rsp_pop_value,
   output logic        [fstk_pkg::STATUS_W-1:0] rsp_status,
   output logic        [fstk_pkg::FILL_W-1:0]   rsp_fill_count,
   output logic                                rsp_is_empty
);
   import fstk_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
      return (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
      return (i == '0) ? LAST_IDX : i - 1'b1;
   endfunction

   logic        [FUNC_W-1:0]   func_ff;
   logic signed [VALUE_W-1:0]  value_ff;
   logic        [IDX_W-1:0]    top_ff, top_in;
   logic        [IDX_W-1:0]    bot_ff, bot_in;
   logic        [CNT_W-1:0]    count_ff, count_in;
   logic                       fwd_ff, fwd_in;
   logic        [STATUS_W-1:0] status_ff, status_in;

   logic                       ram_we, ram_re;
   logic        [IDX_W-1:0]    ram_waddr, ram_raddr;
   logic        [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
   logic signed [63:0]         push_ext;
   logic signed [63:0]         pop_ext;

   logic signed [VALUE_W-1:0]  pop_value_ff;
   logic        [STATUS_W-1:0] rsp_status_ff;
   logic        [FILL_W-1:0]   fill_ff;
   logic                       empty_ff;

   // value is sign-extended, then kept in DATA_WIDTH bits
   assign push_ext  = 64'(value_ff);
   assign ram_wdata = push_ext[DATA_WIDTH-1:0];
   assign pop_ext   = 64'($signed(ram_rdata));

   always_comb begin
      top_in    = top_ff;
      bot_in    = bot_ff;
      count_in  = count_ff;
      fwd_in    = fwd_ff;
      status_in = status_ff;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_waddr = top_ff;
      ram_raddr = bot_ff;
      if (cmd.exec) begin
         status_in = STATUS_OK;
         case (func_ff)
            FUNC_PUSH: begin
               if (count_ff >= FULL_CNT) begin
                  status_in = STATUS_OVERFLOW;
               end else begin
                  ram_we   = 1'b1;
                  count_in = count_ff + 1'b1;
                  if (fwd_ff) begin
                     ram_waddr = top_ff;
                     top_in    = idx_inc(top_ff);
                  end else begin
                     ram_waddr = idx_dec(bot_ff);
                     bot_in    = idx_dec(bot_ff);
                  end
               end
            end
            FUNC_POP: begin
               if (count_ff == '0) begin
                  status_in = STATUS_UNDERFLOW;
               end else begin
                  ram_re   = 1'b1;
                  count_in = count_ff - 1'b1;
                  if (fwd_ff) begin
                     ram_raddr = idx_dec(top_ff);
                     top_in    = idx_dec(top_ff);
                  end else begin
                     ram_raddr = bot_ff;
                     bot_in    = idx_inc(bot_ff);
                  end
               end
            end
            FUNC_FLIP: begin
               fwd_in = !fwd_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff    <= '0;
         bot_ff    <= '0;
         count_ff  <= '0;
         fwd_ff    <= 1'b1;
         status_ff <= STATUS_OK;
      end else begin
         top_ff    <= top_in;
         bot_ff    <= bot_in;
         count_ff  <= count_in;
         fwd_ff    <= fwd_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         value_ff <= req_push_value;
      end
      if (cmd.load) begin
         rsp_status_ff <= status_ff;
         fill_ff       <= FILL_W'(count_ff);
         empty_ff      <= (count_ff == '0);
         if (status_ff == STATUS_UNDERFLOW) begin
            pop_value_ff <= '1;
         end else if (func_ff == FUNC_POP) begin
            pop_value_ff <= pop_ext[VALUE_W-1:0];
         end else begin
            pop_value_ff <= '0;
         end
      end
   end

   fstk_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_pop_value  = pop_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_fill_count = fill_ff;
   assign rsp_is_empty   = empty_ff;

   `FSTK_ASSERT(a_count_bound, clock, reset, count_ff <= FULL_CNT,
                "entry count above depth")
   `FSTK_ASSERT_IMP(a_empty_ptrs_meet, clock, reset, count_ff == '0, top_ff == bot_ff,
                    "empty stack with split indices")
   `FSTK_ASSERT_IMP(a_one_ram_access, clock, reset, ram_we || ram_re,
                    cmd.exec && !(ram_we && ram_re),
                    "store accessed outside exec or twice")

endmodule

>>> rtl/flippable_stack.sv
// Top level of the flippable stack: controller, datapath and channel hookup.
//
// Bounded stack of DEPTH entries of DATA_WIDTH bits in a circular store, with a
// direction bit that a flip toggles; push and pop act at the top end, or at the
// bottom end once flipped. Each item yields one result item. The item is
// captured at its accepting edge. In the exec state the indices are updated and
// the store is accessed; in the load state the registered store read reaches the
// result register, once that register is free or drains. A new item is accepted
// in the cycle after its predecessor's result is loaded, so items are handled
// one at a time; the result register lets the next item start while a result
// waits. Entries of the store are undefined until pushed; no clearing pass
// runs after reset.
module flippable_stack #(
   parameter int DEPTH      = fstk_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = fstk_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   fstk_req_if.sink   req_ch,
   fstk_rsp_if.source rsp_ch
);
   import fstk_pkg::*;

   fstk_cmd_type cmd;

   fstk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   fstk_dp #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_func       (req_ch.func),
      .req_push_value (req_ch.push_value),
      .rsp_pop_value  (rsp_ch.pop_value),
      .rsp_status     (rsp_ch.status),
      .rsp_fill_count (rsp_ch.fill_count),
      .rsp_is_empty   (rsp_ch.is_empty)
   );

endmodule
